// ----- hw/rtl/tmc_pkg.sv -----
// ============================================================================
// tmc_pkg - shared types and constants for the touch median calibrate map
// Request payloads, register indexes and fixed thresholds used by the
// median filter, the serial scaler and the top level.
// ============================================================================
`default_nettype none

package tmc_pkg;

    // Sample and frame geometry
    localparam int SAMPLE_W  = 12;
    localparam int GROUP_N   = 5;
    localparam int FRAME_N   = 10;
    localparam int GROUP_IW  = $clog2(GROUP_N);
    localparam int COUNT_W   = 4;
    localparam int MED_RANK  = 2;
    localparam int RANK_W    = 3;

    // Result field widths
    localparam int SX_W = 8;
    localparam int SY_W = 9;

    // Pressure window on the raw medians
    localparam logic [SAMPLE_W-1:0] PRESS_MIN = 12'd100;
    localparam logic [SAMPLE_W-1:0] PRESS_MAX = 12'd3950;

    // Calibration register reset values
    localparam logic [SAMPLE_W-1:0] WIN_LOW_RST  = 12'd200;
    localparam logic [SAMPLE_W-1:0] WIN_HIGH_RST = 12'd3800;

    // Screen size defaults and scaler factor width
    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 320;
    localparam int FACTOR_W_DEF      = 13;

    // Configuration register indexes
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] REG_X_LOW  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_X_HIGH = 2'd1;
    localparam logic [CFG_IW-1:0] REG_Y_LOW  = 2'd2;
    localparam logic [CFG_IW-1:0] REG_Y_HIGH = 2'd3;

    // Input request: one converter sample
    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic                frame_start;
    } t_tmc_in;

    // Output request: one frame result
    typedef struct packed {
        logic                touched;
        logic [SX_W-1:0]     screen_x;
        logic [SY_W-1:0]     screen_y;
        logic [SAMPLE_W-1:0] median_x;
        logic [SAMPLE_W-1:0] median_y;
    } t_tmc_out;

    // Group store write from the sequencer to the median filter
    typedef struct packed {
        logic                en;
        logic [GROUP_IW-1:0] idx;
        logic [SAMPLE_W-1:0] data;
    } t_grp_wr;

endpackage

`default_nettype wire

// ----- hw/rtl/tmc_median.sv -----
// ============================================================================
// tmc_median - bit-serial median of five
// Holds the five samples of a group in rotating shift registers and picks
// the third smallest one bit per cycle, most significant bit first.
// ============================================================================
`default_nettype none

module tmc_median (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire tmc_pkg::t_grp_wr         i_wr,
    input  wire logic                     i_start,
    output logic                          o_done,
    output logic [tmc_pkg::SAMPLE_W-1:0]  o_median
);
    import tmc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_W);

    logic [SAMPLE_W-1:0] r_entry [GROUP_N];
    logic [GROUP_N-1:0]  r_cand;
    logic [RANK_W-1:0]   r_rank;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [SAMPLE_W-1:0] r_result;

    logic [GROUP_N-1:0]  w_bits;
    logic [GROUP_N-1:0]  w_zeros;
    logic [GROUP_N-1:0]  w_ones;
    logic [RANK_W-1:0]   w_nzero;
    logic                w_take_one;

    // Current bit column of the candidates, and the split by that bit
    always_comb begin
        for (int i = 0; i < GROUP_N; i++) begin
            w_bits[i] = r_entry[i][SAMPLE_W-1];
        end
        w_zeros = r_cand & ~w_bits;
        w_ones  = r_cand & w_bits;
        w_nzero = '0;
        for (int i = 0; i < GROUP_N; i++) begin
            w_nzero = w_nzero + RANK_W'(w_zeros[i]);
        end
        // wanted rank lies among the ones when the zeros are too few
        w_take_one = (r_rank >= w_nzero);
    end

    // Group store: loaded one entry per request, rotated while selecting
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            for (int i = 0; i < GROUP_N; i++) begin
                r_entry[i] <= {r_entry[i][SAMPLE_W-2:0], r_entry[i][SAMPLE_W-1]};
            end
        end else if (i_wr.en) begin
            r_entry[i_wr.idx] <= i_wr.data;
        end
    end

    // Selection control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cand <= '0;
            r_rank <= '0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cand <= '1;
                r_rank <= RANK_W'(MED_RANK);
                r_cnt  <= CNT_W'(SAMPLE_W - 1);
            end else if (r_busy) begin
                r_cand   <= w_take_one ? w_ones : w_zeros;
                r_rank   <= w_take_one ? (r_rank - w_nzero) : r_rank;
                r_result <= {r_result[SAMPLE_W-2:0], w_take_one};
                r_cnt    <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_median = r_result;

endmodule

`default_nettype wire

// ----- hw/rtl/tmc_scale.sv -----
// ============================================================================
// tmc_scale - serial scale by a factor and divide by a span
// Shift-add multiply of a 12-bit distance by a screen size, then restoring
// division of the product by the calibration span, one bit per cycle.
// ============================================================================
`default_nettype none

module tmc_scale #(
    parameter int FACTOR_W = tmc_pkg::FACTOR_W_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [tmc_pkg::SAMPLE_W-1:0] i_dist,
    input  wire logic [tmc_pkg::SAMPLE_W-1:0] i_span,
    input  wire logic [FACTOR_W-1:0]      i_factor,
    output logic                          o_done,
    output logic [FACTOR_W-1:0]           o_quot
);
    import tmc_pkg::*;

    localparam int NW    = SAMPLE_W + FACTOR_W;
    localparam int CNT_W = $clog2(NW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_state;

    t_state              r_state;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [SAMPLE_W-1:0] r_dist;
    logic [SAMPLE_W-1:0] r_span;
    logic [FACTOR_W-1:0] r_factor;
    logic [NW-1:0]       r_acc;
    logic [SAMPLE_W-1:0] r_rem;
    logic [FACTOR_W-1:0] r_quot;

    logic [NW-1:0]       n_acc;
    logic [SAMPLE_W:0]   w_rem_sh;
    logic [SAMPLE_W:0]   w_rem_sub;
    logic                w_fits;
    logic [SAMPLE_W-1:0] n_rem;

    // Multiply step and divide step
    always_comb begin
        n_acc     = {r_acc[NW-2:0], 1'b0}
                  + (r_dist[SAMPLE_W-1] ? NW'(r_factor) : NW'(0));
        w_rem_sh  = {r_rem, r_acc[NW-1]};
        w_fits    = (w_rem_sh >= {1'b0, r_span});
        w_rem_sub = w_rem_sh - {1'b0, r_span};
        n_rem     = w_fits ? w_rem_sub[SAMPLE_W-1:0] : w_rem_sh[SAMPLE_W-1:0];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dist   <= i_dist;
                        r_span   <= i_span;
                        r_factor <= i_factor;
                        r_acc    <= '0;
                        r_cnt    <= CNT_W'(SAMPLE_W - 1);
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc  <= n_acc;
                    r_dist <= {r_dist[SAMPLE_W-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(NW - 1);
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_acc  <= {r_acc[NW-2:0], 1'b0};
                    r_quot <= {r_quot[FACTOR_W-2:0], w_fits};
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ----- hw/rtl/touch_median_calibrate_map.sv -----
// ============================================================================
// touch_median_calibrate_map - resistive touch median filter and calibration
// Median of five per axis, pressure check, linear map to screen pixels.
// ============================================================================
// Takes ten-sample frames (five vertical, then five horizontal; frame_start
// restarts the count) and returns one result per completed frame. The fifth
// sample of a frame starts the bit-serial median of the first group (one bit
// per cycle over 12 bits). The tenth starts the median of the second group,
// then a check step, then two passes through the shared serial scaler (each
// a start step, 12 multiply steps and 12 + F divide steps, where F is the
// bit width of the larger screen dimension), then the output step; no
// sample is taken meanwhile. The next sample is taken as soon as the frame
// result sits in the output register, even if it has not been taken yet.
// Calibration registers should be written only while no frame is in work.
// ============================================================================
`default_nettype none

module touch_median_calibrate_map #(
    parameter int SCREEN_WIDTH  = tmc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tmc_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire tmc_pkg::t_tmc_in            i_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output tmc_pkg::t_tmc_out                o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [tmc_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  wire logic [tmc_pkg::SAMPLE_W-1:0] i_cfg_data
);
    import tmc_pkg::*;

    localparam int SCREEN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int FW         = $clog2(SCREEN_MAX + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MED_V,
        S_MED_X,
        S_CHECK,
        S_MAP_X,
        S_MAP_Y,
        S_OUT
    } t_state;

    // Control and configuration
    t_state              r_state;
    logic [COUNT_W-1:0]  r_count;
    logic [SAMPLE_W-1:0] r_x_low;
    logic [SAMPLE_W-1:0] r_x_high;
    logic [SAMPLE_W-1:0] r_y_low;
    logic [SAMPLE_W-1:0] r_y_high;
    logic                r_out_valid;

    // Frame payload
    logic [SAMPLE_W-1:0] r_my;
    logic [SAMPLE_W-1:0] r_mx;
    logic                r_touch;
    logic [SX_W-1:0]     r_sx;
    logic [SY_W-1:0]     r_sy;
    t_tmc_out            r_out;

    // Submodule links
    t_grp_wr             w_wr;
    logic                w_med_start;
    logic                w_med_done;
    logic [SAMPLE_W-1:0] w_median;
    logic                w_sc_start;
    logic                w_sc_done;
    logic [FW-1:0]       w_quot;

    logic                w_accept;
    logic [COUNT_W-1:0]  w_pos;
    logic                w_range_ok;
    logic                w_touch;
    logic                w_sel_y;
    logic [SAMPLE_W-1:0] w_raw;
    logic [SAMPLE_W-1:0] w_lo;
    logic [SAMPLE_W-1:0] w_hi;
    logic [SAMPLE_W-1:0] w_clamp;
    logic                w_inverted;
    logic [SAMPLE_W-1:0] w_dist;
    logic [SAMPLE_W-1:0] w_span;
    logic [FW-1:0]       w_factor;
    logic [FW-1:0]       w_x_sat;
    logic [FW-1:0]       w_y_sat;

    // Sample position in the frame and group store write
    always_comb begin
        w_accept = i_in_valid && o_in_ready;
        if (i_in.frame_start || (r_count > COUNT_W'(FRAME_N - 1))) begin
            w_pos = '0;
        end else begin
            w_pos = r_count;
        end
        w_wr.en   = w_accept;
        w_wr.data = i_in.adc_sample;
        if (w_pos < COUNT_W'(GROUP_N)) begin
            w_wr.idx = GROUP_IW'(w_pos);
        end else begin
            w_wr.idx = GROUP_IW'(w_pos - COUNT_W'(GROUP_N));
        end
        w_med_start = w_accept && ((w_pos == COUNT_W'(GROUP_N - 1))
                                || (w_pos == COUNT_W'(FRAME_N - 1)));
    end

    // Pressure check and window sanity
    always_comb begin
        w_range_ok = (r_mx >= PRESS_MIN) && (r_mx <= PRESS_MAX)
                  && (r_my >= PRESS_MIN) && (r_my <= PRESS_MAX);
        w_touch    = w_range_ok && (r_x_low != r_x_high) && (r_y_low != r_y_high);
    end

    // Axis operands for the scaler: x while checking, y after x is done
    always_comb begin
        w_sel_y    = (r_state == S_MAP_X);
        w_raw      = w_sel_y ? r_my : r_mx;
        w_lo       = w_sel_y ? r_y_low : r_x_low;
        w_hi       = w_sel_y ? r_y_high : r_x_high;
        w_factor   = w_sel_y ? FW'(SCREEN_HEIGHT) : FW'(SCREEN_WIDTH);
        w_inverted = (w_lo > w_hi);
        if (w_raw < w_lo) begin
            w_clamp = w_lo;
        end else if (w_raw > w_hi) begin
            w_clamp = w_hi;
        end else begin
            w_clamp = w_raw;
        end
        // inverted window: distance equals span, so the quotient is the factor
        if (w_inverted) begin
            w_dist = SAMPLE_W'(1);
            w_span = SAMPLE_W'(1);
        end else begin
            w_dist = w_clamp - w_lo;
            w_span = w_hi - w_lo;
        end
        w_sc_start = (r_state == S_CHECK) || ((r_state == S_MAP_X) && w_sc_done);
    end

    // Saturation to the screen; y is also flipped top to bottom
    always_comb begin
        if (w_quot >= FW'(SCREEN_WIDTH)) begin
            w_x_sat = FW'(SCREEN_WIDTH - 1);
        end else begin
            w_x_sat = w_quot;
        end
        if (w_quot >= FW'(SCREEN_HEIGHT)) begin
            w_y_sat = '0;
        end else begin
            w_y_sat = FW'(SCREEN_HEIGHT - 1) - w_quot;
        end
    end

    // Calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low  <= WIN_LOW_RST;
            r_x_high <= WIN_HIGH_RST;
            r_y_low  <= WIN_LOW_RST;
            r_y_high <= WIN_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_LOW:  r_x_low  <= i_cfg_data;
                REG_X_HIGH: r_x_high <= i_cfg_data;
                REG_Y_LOW:  r_y_low  <= i_cfg_data;
                REG_Y_HIGH: r_y_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_my        <= '0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_pos == COUNT_W'(GROUP_N - 1)) begin
                            r_state <= S_MED_V;
                        end else if (w_pos == COUNT_W'(FRAME_N - 1)) begin
                            r_state <= S_MED_X;
                        end else begin
                            r_count <= w_pos + 1'b1;
                        end
                    end
                end
                S_MED_V: begin
                    if (w_med_done) begin
                        r_my    <= w_median;
                        r_count <= COUNT_W'(GROUP_N);
                        r_state <= S_IDLE;
                    end
                end
                S_MED_X: begin
                    if (w_med_done) begin
                        r_mx    <= w_median;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_touch <= w_touch;
                    r_state <= S_MAP_X;
                end
                S_MAP_X: begin
                    if (w_sc_done) begin
                        r_sx    <= r_touch ? SX_W'(w_x_sat) : '0;
                        r_state <= S_MAP_Y;
                    end
                end
                S_MAP_Y: begin
                    if (w_sc_done) begin
                        r_sy    <= r_touch ? SY_W'(w_y_sat) : '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_out.touched  <= r_touch;
                        r_out.screen_x <= r_sx;
                        r_out.screen_y <= r_sy;
                        r_out.median_x <= r_mx;
                        r_out.median_y <= r_my;
                        r_count        <= '0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Median filter with the group store
    tmc_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_start  (w_med_start),
        .o_done   (w_med_done),
        .o_median (w_median)
    );

    // Shared serial scaler for both axes
    tmc_scale #(
        .FACTOR_W (FW)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_sc_start),
        .i_dist   (w_dist),
        .i_span   (w_span),
        .i_factor (w_factor),
        .o_done   (w_sc_done),
        .o_quot   (w_quot)
    );

endmodule

`default_nettype wire
